>>> rtl/iasu_pkg.sv
// ----------------------------------------------------------------------------
// iasu_pkg
// Shared codes and defaults for the indexed array search and update block.
// ----------------------------------------------------------------------------
package iasu_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 64;

  // operation codes on the mode input
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_MODIFY = 2'd1;
  localparam logic [1:0] MODE_APPEND = 2'd2;
  localparam logic [1:0] MODE_ZERO   = 2'd3;

  // status codes on the result
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMATCH = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

endpackage

>>> rtl/iasu_ram.sv
// ----------------------------------------------------------------------------
// iasu_ram
// Table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module iasu_ram #(
  parameter int DEPTH  = iasu_pkg::DEPTH_DEFAULT,
  parameter int ADDR_W = 6,
  parameter int DATA_W = iasu_pkg::DATA_W
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/indexed_array_search_update_top.sv
// ----------------------------------------------------------------------------
// indexed_array_search_update_top
// Table of signed words with lookup, modify, append and zero operations.
// ----------------------------------------------------------------------------
// Modify, append and zero: result registered in the cycle after accept, busy stays low,
// so a new item can be accepted every cycle.
// Lookup: one table read per cycle through the single RAM read port; busy is
// held while the scan runs. A match is held back until the next one is found or
// the scan ends, at most one result per cycle. Results cannot be stalled.
// Reset clears the entry count and all control; table contents stay undefined.
// ----------------------------------------------------------------------------
module indexed_array_search_update_top #(
  parameter int DEPTH = iasu_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [5:0]         index,
  input  logic signed [31:0] value,
  output logic               done,
  output logic [1:0]         status,
  output logic [5:0]         match_index,
  output logic               last,
  output logic [6:0]         entry_count
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = iasu_pkg::DATA_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  // controller states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  // control registers
  logic             state, state_next;
  logic [CNT_W-1:0] used_count, used_count_next;
  logic [CNT_W-1:0] scan_addr;   // next entry to read
  logic             cmp_valid;   // rdata belongs to cmp_addr
  logic             pend_valid;  // a match is held back so the final one can carry last

  // payload registers
  logic [ADDR_W-1:0] cmp_addr;
  logic [ADDR_W-1:0] pend_addr;
  logic [DATA_W-1:0] value_q;

  // result register next values
  logic       done_next;
  logic [1:0] status_next;
  logic [5:0] match_index_next;
  logic       last_next;

  // RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic        accept;
  logic        issue;
  logic        hit;
  logic        finish;
  logic        in_range;
  logic        full;
  logic [31:0] index_wide;
  logic [31:0] count_wide;
  logic [31:0] count_next_wide;
  logic [31:0] pend_wide;

  assign busy   = (state == S_SCAN);
  assign accept = start && !busy;

  // scan pipeline: read issued this cycle, compared the next
  assign issue  = (state == S_SCAN) && (scan_addr < used_count);
  assign hit    = cmp_valid && (ram_rdata == value_q);
  assign finish = (state == S_SCAN) && !issue && !cmp_valid;

  // index bound check done at 32 bits so any DEPTH works against the 6-bit index
  assign index_wide = 32'(index);
  assign count_wide = 32'(used_count);
  assign in_range   = index_wide < count_wide;
  assign full       = used_count >= DEPTH_CNT;

  assign pend_wide       = 32'(pend_addr);
  assign count_next_wide = 32'(used_count_next);

  assign ram_raddr = scan_addr[ADDR_W-1:0];

  // write decode for the modify, append and zero operations
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = index_wide[ADDR_W-1:0];
    ram_wdata       = value;
    used_count_next = used_count;
    unique case (mode) inside
      iasu_pkg::MODE_MODIFY: begin
        ram_we = accept && in_range;
      end
      iasu_pkg::MODE_ZERO: begin
        ram_we    = accept && in_range;
        ram_wdata = '0;
      end
      iasu_pkg::MODE_APPEND: begin
        ram_we    = accept && !full;
        ram_waddr = used_count[ADDR_W-1:0];
        if (accept && !full) begin
          used_count_next = used_count + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // result selection; accept only happens in idle, scan results only in scan
  always_comb begin
    done_next        = 1'b0;
    status_next      = iasu_pkg::ST_OK;
    match_index_next = '0;
    last_next        = 1'b1;
    if (accept && (mode != iasu_pkg::MODE_LOOKUP)) begin
      done_next = 1'b1;
      unique case (mode) inside
        iasu_pkg::MODE_MODIFY, iasu_pkg::MODE_ZERO: begin
          status_next = in_range ? iasu_pkg::ST_OK : iasu_pkg::ST_RANGE;
        end
        iasu_pkg::MODE_APPEND: begin
          status_next = full ? iasu_pkg::ST_FULL : iasu_pkg::ST_OK;
        end
        default: begin
        end
      endcase
    end else if (hit && pend_valid) begin
      // a newer match exists, so the held one is not the last
      done_next        = 1'b1;
      match_index_next = pend_wide[5:0];
      last_next        = 1'b0;
    end else if (finish) begin
      done_next = 1'b1;
      if (pend_valid) begin
        match_index_next = pend_wide[5:0];
      end else begin
        status_next = iasu_pkg::ST_NOMATCH;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (mode == iasu_pkg::MODE_LOOKUP)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      scan_addr  <= '0;
      cmp_valid  <= 1'b0;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      used_count <= used_count_next;
      done       <= done_next;
      if (accept) begin
        scan_addr  <= '0;
        cmp_valid  <= 1'b0;
        pend_valid <= 1'b0;
      end else begin
        cmp_valid <= issue;
        if (issue) begin
          scan_addr <= scan_addr + CNT_W'(1);
        end
        if (hit) begin
          pend_valid <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      value_q <= value;
    end
    if (issue) begin
      cmp_addr <= scan_addr[ADDR_W-1:0];
    end
    if (hit) begin
      pend_addr <= cmp_addr;
    end
    status      <= status_next;
    match_index <= match_index_next;
    last        <= last_next;
    entry_count <= count_next_wide[6:0];
  end

  iasu_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= DEPTH_CNT)
    else $error("entry count above table depth");

  a_cmp_in_use: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (CNT_W'(cmp_addr) < used_count))
    else $error("compare on an entry not in use");

  a_scan_ends_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && state_next == S_IDLE) |=> (done && last))
    else $error("lookup ended without a final result");

  a_nomatch_form: assert property (@(posedge clk) disable iff (rst)
    (done && status == iasu_pkg::ST_NOMATCH) |-> (last && match_index == 6'd0))
    else $error("no-match result malformed");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && used_count != $past(used_count))
      |-> (used_count == $past(used_count) + CNT_W'(1)))
    else $error("entry count moved by other than one");
`endif

endmodule
